// File: design/mrs_pkg.sv
// shared types, constants and filter function for the message ring store
package mrs_pkg;

  // storage sizes
  localparam int RING_DEPTH = 32;
  localparam int DM_DEPTH   = 4;
  localparam int QDEPTH     = 2;

  // derived widths
  localparam int RW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW  = $clog2(RING_DEPTH + 1);
  localparam int DW  = (DM_DEPTH > 1) ? $clog2(DM_DEPTH) : 1;
  localparam int DFW = $clog2(DM_DEPTH + 1);
  localparam int QW  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);
  localparam int TW  = 6;
  localparam int XW  = (CW > TW) ? CW : TW;
  localparam int MAX_RES = 32;

  // function codes
  localparam logic [2:0] FN_APPEND = 3'd0;
  localparam logic [2:0] FN_SNAP   = 3'd1;
  localparam logic [2:0] FN_GET    = 3'd2;
  localparam logic [2:0] FN_MARK   = 3'd3;
  localparam logic [2:0] FN_COUNT  = 3'd4;
  localparam logic [2:0] FN_USNAP  = 3'd5;

  // filter codes
  localparam logic [2:0] FLT_DM  = 3'd0;
  localparam logic [2:0] FLT_ALL = 3'd1;
  localparam logic [2:0] FLT_CH0 = 3'd2;
  localparam logic [2:0] FLT_CH1 = 3'd3;
  localparam logic [2:0] FLT_CH2 = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_OWN   = 2'd0;
  localparam logic [1:0] CFG_FILT  = 2'd1;
  localparam logic [1:0] CFG_BCAST = 2'd2;

  typedef struct packed {
    logic [31:0] own_node;
    logic [2:0]  append_filter;
    logic [31:0] broadcast_node;
  } cfg_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] from_node;
    logic [31:0] to_node;
    logic [31:0] time_val;
    logic [2:0]  channel;
    logic        outgoing;
    logic        rd;
    logic        hot;
  } rec_t;

  typedef struct packed {
    logic [2:0]  func;
    rec_t        rec;
    logic        accept;
    logic        dm;
    logic [31:0] msg_id;
    logic [2:0]  filter;
    logic [5:0]  maxc;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    rec_t        rec;
    logic [5:0]  tally;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_EV,
    ST_FIN,
    ST_DM
  } state_t;

  // record filter shared by append and snapshot
  function automatic logic passes(rec_t r, logic [2:0] f, cfg_t c);
    logic res;
    res = 1'b1;
    case (f)
      FLT_DM:  res = (r.to_node == c.own_node) ||
                     (r.outgoing && (r.to_node != c.broadcast_node));
      FLT_ALL: res = !r.hot;
      FLT_CH0: res = !r.hot && (r.channel == 3'd0);
      FLT_CH1: res = !r.hot && (r.channel == 3'd1);
      FLT_CH2: res = !r.hot && (r.channel == 3'd2);
      default: res = 1'b1;
    endcase
    return res;
  endfunction

endpackage

// File: design/mrs_front.sv
// front end: accepts requests, classifies appends and queues commands
module mrs_front (
  input  logic           clk,
  input  logic           rst,
  input  mrs_pkg::cfg_t  cfg,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [175:0]   s_tdata,
  input  logic [2:0]     s_tuser,
  output logic           cmd_valid,
  output mrs_pkg::cmd_t  cmd,
  input  logic           cmd_pop
);

  mrs_pkg::cmd_t                dec;
  mrs_pkg::cmd_t                q [mrs_pkg::QDEPTH];
  logic [mrs_pkg::QW-1:0]       wp;
  logic [mrs_pkg::QW-1:0]       rp;
  logic [mrs_pkg::QCW-1:0]      cnt;
  logic                         push;
  logic [31:0]                  ts;
  logic [5:0]                   maxc_in;

  // field decode and append classification
  always_comb begin
    ts      = s_tdata[98:67];
    maxc_in = s_tdata[173:168];
    dec = '0;
    dec.func              = s_tuser;
    dec.rec.from_node     = s_tdata[31:0];
    dec.rec.to_node       = s_tdata[63:32];
    dec.rec.channel       = s_tdata[66:64];
    dec.rec.time_val      = (ts == 32'd0) ? s_tdata[130:99] : ts;
    dec.rec.outgoing      = s_tdata[131];
    dec.rec.hot           = s_tdata[132];
    dec.msg_id            = s_tdata[164:133];
    dec.filter            = s_tdata[167:165];
    dec.maxc              = (maxc_in > 6'(mrs_pkg::MAX_RES)) ?
                            6'(mrs_pkg::MAX_RES) : maxc_in;
    dec.dm                = !dec.rec.outgoing && (dec.rec.to_node == cfg.own_node);
    dec.accept            = dec.rec.outgoing ||
                            (dec.rec.to_node == cfg.own_node) ||
                            mrs_pkg::passes(dec.rec, cfg.append_filter, cfg);
  end

  // command queue handshake
  assign s_tready  = (cnt != mrs_pkg::QCW'(mrs_pkg::QDEPTH));
  assign push      = s_tvalid && s_tready;
  assign cmd_valid = (cnt != '0);
  assign cmd       = q[rp];

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == mrs_pkg::QW'(mrs_pkg::QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (cmd_pop) begin
        rp <= (rp == mrs_pkg::QW'(mrs_pkg::QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !cmd_pop) begin
        cnt <= cnt + 1'b1;
      end else if (!push && cmd_pop) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= dec;
    end
  end

endmodule

// File: design/mrs_back.sv
// back end: ring store, unread queue and result sequencing
module mrs_back (
  input  logic           clk,
  input  logic           rst,
  input  mrs_pkg::cfg_t  cfg,
  input  logic           cmd_valid,
  input  mrs_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output mrs_pkg::res_t  out_res
);

  localparam int RW  = mrs_pkg::RW;
  localparam int CW  = mrs_pkg::CW;
  localparam int DW  = mrs_pkg::DW;
  localparam int DFW = mrs_pkg::DFW;
  localparam int TW  = mrs_pkg::TW;
  localparam int XW  = mrs_pkg::XW;

  mrs_pkg::state_t state, state_next;
  mrs_pkg::cmd_t   cur;
  mrs_pkg::rec_t   mem [mrs_pkg::RING_DEPTH];
  mrs_pkg::rec_t   rdata;
  mrs_pkg::rec_t   dm_q [mrs_pkg::DM_DEPTH];
  mrs_pkg::rec_t   hit;
  mrs_pkg::rec_t   new_rec;
  mrs_pkg::rec_t   mem_wd;
  mrs_pkg::res_t   res_fin;

  logic [RW-1:0]   write_pos;
  logic [CW-1:0]   fill;
  logic [31:0]     next_serial;
  logic [DFW-1:0]  dm_fill;
  logic [DFW-1:0]  dm_fill_after;
  logic [CW-1:0]   iss;
  logic            pend;
  logic [RW-1:0]   pidx;
  logic            found;
  logic [RW-1:0]   hit_idx;
  logic [CW-1:0]   match_cnt;
  logic [CW-1:0]   seen;
  logic [CW-1:0]   skip;
  logic [TW-1:0]   snap_n;
  logic [TW-1:0]   k;
  logic [XW-1:0]   n_full;
  logic [TW-1:0]   usnap_n;

  logic            out_free;
  logic            rd_en;
  logic [RW-1:0]   rd_addr;
  logic [RW-1:0]   start;
  logic [CW:0]     slot_sum;
  logic            ev_pass;
  logic            ev_hit;
  logic            scan_done;
  logic            k_last;
  logic            mem_we;
  logic [RW-1:0]   mem_wa;
  logic            dm_hit;
  logic [DW-1:0]   dm_pos;

  // ring slot of the current scan position, oldest entry first
  always_comb begin
    start    = (fill == CW'(mrs_pkg::RING_DEPTH)) ? write_pos : '0;
    slot_sum = (CW+1)'(start) + (CW+1)'(iss);
    if (slot_sum >= (CW+1)'(mrs_pkg::RING_DEPTH)) begin
      slot_sum = slot_sum - (CW+1)'(mrs_pkg::RING_DEPTH);
    end
  end

  // evaluation of the registered ring read
  always_comb begin
    ev_pass   = mrs_pkg::passes(rdata, cur.filter, cfg);
    ev_hit    = pend && (cur.func != mrs_pkg::FN_SNAP) && (rdata.id == cur.msg_id);
    scan_done = !pend && (iss == fill);
    n_full    = (XW'(match_cnt) < XW'(cur.maxc)) ? XW'(match_cnt) : XW'(cur.maxc);
    skip      = match_cnt - CW'(snap_n);
    k_last    = ((k + TW'(1)) == snap_n);
    usnap_n   = (TW'(dm_fill) < cmd.maxc) ? TW'(dm_fill) : cmd.maxc;
  end

  // unread queue search, lowest match wins
  always_comb begin
    dm_hit = 1'b0;
    dm_pos = '0;
    for (int j = mrs_pkg::DM_DEPTH - 1; j >= 0; j--) begin
      if ((DFW'(j) < dm_fill) && (dm_q[j].id == cur.msg_id)) begin
        dm_hit = 1'b1;
        dm_pos = DW'(j);
      end
    end
    dm_fill_after = dm_fill - DFW'(dm_hit);
  end

  // record stored on append
  always_comb begin
    new_rec    = cur.rec;
    new_rec.id = next_serial;
    new_rec.rd = 1'b0;
  end

  // single result of the finishing step
  always_comb begin
    res_fin      = '0;
    res_fin.last = 1'b1;
    case (cur.func)
      mrs_pkg::FN_APPEND: begin
        if (cur.accept) begin
          res_fin.valid = 1'b1;
          res_fin.rec   = new_rec;
        end
      end
      mrs_pkg::FN_GET: begin
        if (found) begin
          res_fin.valid = 1'b1;
          res_fin.rec   = hit;
        end
      end
      mrs_pkg::FN_MARK: begin
        if (found) begin
          res_fin.valid  = 1'b1;
          res_fin.rec    = hit;
          res_fin.rec.rd = 1'b1;
        end
        res_fin.tally = TW'(dm_fill_after);
      end
      mrs_pkg::FN_COUNT: begin
        res_fin.tally = TW'(dm_fill);
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mrs_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.func) inside
            mrs_pkg::FN_SNAP, mrs_pkg::FN_GET, mrs_pkg::FN_MARK:
              state_next = mrs_pkg::ST_SCAN;
            mrs_pkg::FN_USNAP:
              state_next = (usnap_n != '0) ? mrs_pkg::ST_DM : mrs_pkg::ST_FIN;
            default:
              state_next = mrs_pkg::ST_FIN;
          endcase
        end
      end
      mrs_pkg::ST_SCAN: begin
        if (ev_hit) begin
          state_next = mrs_pkg::ST_FIN;
        end else if (scan_done) begin
          if ((cur.func == mrs_pkg::FN_SNAP) && (n_full != '0)) begin
            state_next = mrs_pkg::ST_EMIT_RD;
          end else begin
            state_next = mrs_pkg::ST_FIN;
          end
        end
      end
      mrs_pkg::ST_EMIT_RD: begin
        state_next = mrs_pkg::ST_EMIT_EV;
      end
      mrs_pkg::ST_EMIT_EV: begin
        if (!ev_pass || (seen < skip)) begin
          state_next = mrs_pkg::ST_EMIT_RD;
        end else if (out_free) begin
          state_next = k_last ? mrs_pkg::ST_IDLE : mrs_pkg::ST_EMIT_RD;
        end
      end
      mrs_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = mrs_pkg::ST_IDLE;
        end
      end
      mrs_pkg::ST_DM: begin
        if (out_free && k_last) begin
          state_next = mrs_pkg::ST_IDLE;
        end
      end
      default: state_next = mrs_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    out_free = !out_valid || out_ready;
    cmd_pop  = (state == mrs_pkg::ST_IDLE) && cmd_valid;
    rd_en    = ((state == mrs_pkg::ST_SCAN) && (iss < fill) && !ev_hit) ||
               (state == mrs_pkg::ST_EMIT_RD);
    rd_addr  = (cur.func == mrs_pkg::FN_SNAP) ? slot_sum[RW-1:0] : iss[RW-1:0];
    mem_we   = (state == mrs_pkg::ST_FIN) && out_free &&
               (((cur.func == mrs_pkg::FN_APPEND) && cur.accept) ||
                ((cur.func == mrs_pkg::FN_MARK) && found));
    mem_wa   = (cur.func == mrs_pkg::FN_APPEND) ? write_pos : hit_idx;
    mem_wd   = new_rec;
    if (cur.func != mrs_pkg::FN_APPEND) begin
      mem_wd    = hit;
      mem_wd.rd = 1'b1;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ring memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // sequencing datapath and store bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      write_pos   <= '0;
      fill        <= '0;
      next_serial <= 32'd1;
      dm_fill     <= '0;
      pend        <= 1'b0;
      found       <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        // take the next command
        mrs_pkg::ST_IDLE: begin
          if (cmd_valid) begin
            cur       <= cmd;
            iss       <= '0;
            pend      <= 1'b0;
            found     <= 1'b0;
            match_cnt <= '0;
            seen      <= '0;
            k         <= '0;
            snap_n    <= usnap_n;
          end
        end
        // pipelined pass: count matches or look up an id
        mrs_pkg::ST_SCAN: begin
          pend <= rd_en;
          pidx <= rd_addr;
          if (rd_en) begin
            iss <= iss + 1'b1;
          end
          if (pend && (cur.func == mrs_pkg::FN_SNAP) && ev_pass) begin
            match_cnt <= match_cnt + 1'b1;
          end
          if (ev_hit) begin
            found   <= 1'b1;
            hit     <= rdata;
            hit_idx <= pidx;
          end
          if (scan_done && !ev_hit) begin
            snap_n <= TW'(n_full);
            iss    <= '0;
          end
        end
        // emitting pass over the ring
        mrs_pkg::ST_EMIT_EV: begin
          if (!ev_pass) begin
            iss <= iss + 1'b1;
          end else if (seen < skip) begin
            seen <= seen + 1'b1;
            iss  <= iss + 1'b1;
          end else if (out_free) begin
            out_valid     <= 1'b1;
            out_res.valid <= 1'b1;
            out_res.rec   <= rdata;
            out_res.tally <= snap_n;
            out_res.last  <= k_last;
            k             <= k + 1'b1;
            iss           <= iss + 1'b1;
          end
        end
        // single result and store updates
        mrs_pkg::ST_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_res   <= res_fin;
            if ((cur.func == mrs_pkg::FN_APPEND) && cur.accept) begin
              next_serial <= next_serial + 32'd1;
              write_pos   <= (write_pos == RW'(mrs_pkg::RING_DEPTH - 1)) ?
                             '0 : write_pos + 1'b1;
              if (fill != CW'(mrs_pkg::RING_DEPTH)) begin
                fill <= fill + 1'b1;
              end
              if (cur.dm) begin
                if (dm_fill == DFW'(mrs_pkg::DM_DEPTH)) begin
                  for (int j = 0; j < mrs_pkg::DM_DEPTH - 1; j++) begin
                    dm_q[j] <= dm_q[j+1];
                  end
                  dm_q[mrs_pkg::DM_DEPTH-1] <= new_rec;
                end else begin
                  dm_q[dm_fill[DW-1:0]] <= new_rec;
                  dm_fill <= dm_fill + 1'b1;
                end
              end
            end
            if ((cur.func == mrs_pkg::FN_MARK) && dm_hit) begin
              for (int j = 0; j < mrs_pkg::DM_DEPTH - 1; j++) begin
                if (DW'(j) >= dm_pos) begin
                  dm_q[j] <= dm_q[j+1];
                end
              end
              dm_fill <= dm_fill_after;
            end
          end
        end
        // unread queue run
        mrs_pkg::ST_DM: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_res.valid <= 1'b1;
            out_res.rec   <= dm_q[k[DW-1:0]];
            out_res.tally <= snap_n;
            out_res.last  <= k_last;
            k             <= k + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: design/message_ring_store_with_dm_queue_top.sv
// top level of the message ring store with unread direct-message queue
// Requests enter on the s_ side into a two-entry command queue, so the next
// request is taken while the back end still works or a result waits on the
// m_ side. Append, unread count, unread-snapshot of an empty queue and unused
// codes go straight to the finishing step. Lookup and mark read scan the ring
// once through its single read port. A snapshot makes a counting pass over
// the ring, then an emitting pass that reads and evaluates each visited ring
// entry in turn; the ring holds up to 32 entries. An unread snapshot gives one
// result per cycle while m_tready is held high. Each request's final result has tlast.
module message_ring_store_with_dm_queue_top (
  input  logic          clk,
  input  logic          rst,
  // request transaction
  input  logic          s_tvalid,
  output logic          s_tready,
  // from_node, to_node, channel, timestamp, now_time, outgoing, is_hot,
  // msg_id, filter_code, max_count
  input  logic [175:0]  s_tdata,
  // func
  input  logic [2:0]    s_tuser,
  // result transaction
  output logic          m_tvalid,
  input  logic          m_tready,
  // rec_id, rec_from, rec_to, rec_channel, rec_time, rec_outgoing,
  // rec_read, rec_hot, tally
  output logic [143:0]  m_tdata,
  // result_valid
  output logic [0:0]    m_tuser,
  output logic          m_tlast,
  // configuration write
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  mrs_pkg::cfg_t cfg;
  mrs_pkg::cmd_t cmd;
  mrs_pkg::res_t res;
  logic          cmd_valid;
  logic          cmd_pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_node       <= 32'd0;
      cfg.append_filter  <= 3'd1;
      cfg.broadcast_node <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mrs_pkg::CFG_OWN:   cfg.own_node       <= cfg_data;
        mrs_pkg::CFG_FILT:  cfg.append_filter  <= cfg_data[2:0];
        mrs_pkg::CFG_BCAST: cfg.broadcast_node <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  mrs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // result packing
  assign m_tdata = {4'b0, res.tally, res.rec.hot, res.rec.rd, res.rec.outgoing,
                    res.rec.time_val, res.rec.channel, res.rec.to_node,
                    res.rec.from_node, res.rec.id};
  assign m_tuser = res.valid;
  assign m_tlast = res.last;

endmodule
